// File: sv/llqm_pkg.sv
// Package for the linked-list queue manager: field widths, pointer type,
// command and status codes, null pointer and the pointer test. No dependencies.
`default_nettype none

package llqm_pkg;

    // Storage sizing
    localparam int NUM_ITEMS  = 256;
    localparam int NUM_QUEUES = 4;

    localparam int IDX_W = $clog2(NUM_ITEMS);
    localparam int PTR_W = $clog2(NUM_ITEMS + 1);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // Port field widths
    localparam int CMD_W    = 3;
    localparam int QSEL_W   = 2;
    localparam int ITEM_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef logic [PTR_W-1:0] t_ptr;

    localparam t_ptr NIL_PTR = PTR_W'(NUM_ITEMS);

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PREPEND    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SPLIT      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    function automatic logic is_item(input t_ptr p);
        return p < NIL_PTR;
    endfunction

endpackage

`default_nettype wire

// File: sv/llqm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module llqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/linked_list_queue_manager_top.sv
// Linked-list queue manager: a link memory holds the next pointer of every
// item; a queue table (two copies, one read port each) holds head and tail of
// every queue. Each accepted command word returns one result word, one at a
// time. Beyond the fetch, push back onto a non-empty queue adds a write of the
// old tail's link, pop adds a link-memory read, append and prepend add a write
// of the source queue entry, and a split that moves items walks the source
// with one link-memory read per link, then writes the source entry. A new word
// is taken the cycle after the result is registered, even if that result is
// still stalled. The queue table starts empty through per-queue valid bits, so
// there is no clearing pass; link entries are only read after being written.
// Depends on llqm_pkg and llqm_ram.
`default_nettype none

module linked_list_queue_manager_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [llqm_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [llqm_pkg::QSEL_W-1:0]   i_queue_sel,
    input  wire logic [llqm_pkg::QSEL_W-1:0]   i_other_queue,
    input  wire logic [llqm_pkg::ITEM_W-1:0]   i_item_in,
    input  wire logic [llqm_pkg::COUNT_W-1:0]  i_count,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [llqm_pkg::ITEM_W-1:0]   o_item_out,
    output logic                               o_item_valid,
    output logic      [llqm_pkg::STATUS_W-1:0] o_status,
    output logic                               o_queue_empty,
    output logic      [llqm_pkg::ITEM_W-1:0]   o_front_item,
    output logic      [llqm_pkg::ITEM_W-1:0]   o_back_item
);

    import llqm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LINK2,
        S_POPW,
        S_WALK,
        S_SRCW,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // latched command word
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [QSEL_W-1:0]  r_qsel, n_qsel;
    logic [QSEL_W-1:0]  r_oq, n_oq;
    logic [ITEM_W-1:0]  r_item, n_item;
    logic [COUNT_W-1:0] r_count, n_count;

    // working copies of head/tail for destination and source
    t_ptr r_hd, n_hd;
    t_ptr r_td, n_td;
    t_ptr r_hs, n_hs;
    t_ptr r_ts, n_ts;
    t_ptr r_last, n_last;
    logic [COUNT_W-1:0]  r_walk, n_walk;
    logic [2*PTR_W-1:0]  r_src, n_src;
    logic [STATUS_W-1:0] r_st, n_st;
    logic [ITEM_W-1:0]   r_popped, n_popped;
    logic                r_pvalid, n_pvalid;

    logic [NUM_QUEUES-1:0] r_qvld, n_qvld;
    logic r_vld_d, n_vld_d;
    logic r_vld_s, n_vld_s;

    // registered outputs
    logic                r_ovld, n_ovld;
    logic [ITEM_W-1:0]   r_o_item, n_o_item;
    logic                r_o_ival, n_o_ival;
    logic [STATUS_W-1:0] r_o_st, n_o_st;
    logic                r_o_empty, n_o_empty;
    logic [ITEM_W-1:0]   r_o_front, n_o_front;
    logic [ITEM_W-1:0]   r_o_back, n_o_back;

    // memory ports
    logic               link_we;
    logic [IDX_W-1:0]   link_wa;
    t_ptr               link_wd;
    logic [IDX_W-1:0]   link_ra;
    t_ptr               link_rd;
    logic               q_we;
    logic [QIDX_W-1:0]  q_wa;
    logic [2*PTR_W-1:0] q_wd;
    logic [2*PTR_W-1:0] qd_rd;
    logic [2*PTR_W-1:0] qs_rd;

    // decoded operands
    logic d_ok, s_ok, it_ok, two_q, bad;
    logic [QIDX_W-1:0] di, si;
    t_ptr itp;
    t_ptr w_hd, w_td, w_hs, w_ts;
    logic d_item;

    llqm_ram #(.WIDTH(PTR_W), .DEPTH(NUM_ITEMS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (link_ra),
        .o_rdata (link_rd)
    );

    // queue table, copy read at the destination queue
    llqm_ram #(.WIDTH(2*PTR_W), .DEPTH(NUM_QUEUES)) u_qtab_d (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_wa),
        .i_wdata (q_wd),
        .i_raddr (QIDX_W'(i_queue_sel)),
        .o_rdata (qd_rd)
    );

    // queue table, copy read at the source queue
    llqm_ram #(.WIDTH(2*PTR_W), .DEPTH(NUM_QUEUES)) u_qtab_s (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_wa),
        .i_wdata (q_wd),
        .i_raddr (QIDX_W'(i_other_queue)),
        .o_rdata (qs_rd)
    );

    assign d_ok  = 32'(r_qsel) < 32'(NUM_QUEUES);
    assign s_ok  = 32'(r_oq) < 32'(NUM_QUEUES);
    assign it_ok = 32'(r_item) < 32'(NUM_ITEMS);
    assign two_q = (r_cmd == CMD_APPEND) || (r_cmd == CMD_PREPEND) || (r_cmd == CMD_SPLIT);
    assign bad   = !d_ok || (two_q && !s_ok) || (two_q && (r_qsel == r_oq)) ||
                   (((r_cmd == CMD_PUSH_BACK) || (r_cmd == CMD_PUSH_FRONT)) && !it_ok);
    assign di    = QIDX_W'(r_qsel);
    assign si    = QIDX_W'(r_oq);
    assign itp   = PTR_W'(r_item);

    // never-written queue entries read as empty
    assign w_hd = r_vld_d ? qd_rd[2*PTR_W-1:PTR_W] : NIL_PTR;
    assign w_td = r_vld_d ? qd_rd[PTR_W-1:0]       : NIL_PTR;
    assign w_hs = r_vld_s ? qs_rd[2*PTR_W-1:PTR_W] : NIL_PTR;
    assign w_ts = r_vld_s ? qs_rd[PTR_W-1:0]       : NIL_PTR;

    assign d_item = d_ok && is_item(r_hd);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_qsel   = r_qsel;
        n_oq     = r_oq;
        n_item   = r_item;
        n_count  = r_count;
        n_hd     = r_hd;
        n_td     = r_td;
        n_hs     = r_hs;
        n_ts     = r_ts;
        n_last   = r_last;
        n_walk   = r_walk;
        n_src    = r_src;
        n_st     = r_st;
        n_popped = r_popped;
        n_pvalid = r_pvalid;
        n_qvld   = r_qvld;
        n_vld_d  = r_vld_d;
        n_vld_s  = r_vld_s;
        n_ovld    = r_ovld && i_stall;
        n_o_item  = r_o_item;
        n_o_ival  = r_o_ival;
        n_o_st    = r_o_st;
        n_o_empty = r_o_empty;
        n_o_front = r_o_front;
        n_o_back  = r_o_back;
        link_we = 1'b0;
        link_wa = '0;
        link_wd = NIL_PTR;
        link_ra = '0;
        q_we    = 1'b0;
        q_wa    = di;
        q_wd    = {r_hd, r_td};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_qsel  = i_queue_sel;
                    n_oq    = i_other_queue;
                    n_item  = i_item_in;
                    n_count = i_count;
                    n_vld_d = r_qvld[QIDX_W'(i_queue_sel)];
                    n_vld_s = r_qvld[QIDX_W'(i_other_queue)];
                    n_state = S_FETCH;
                end
            end

            S_FETCH: begin
                n_hd     = w_hd;
                n_td     = w_td;
                n_hs     = w_hs;
                n_ts     = w_ts;
                n_st     = ST_DONE;
                n_popped = '0;
                n_pvalid = 1'b0;
                n_state  = S_DONE;
                if (bad) begin
                    n_st = ST_BAD;
                end else begin
                    case (r_cmd)
                        CMD_PUSH_BACK: begin
                            link_we = 1'b1;
                            link_wa = IDX_W'(r_item);
                            link_wd = NIL_PTR;
                            n_hd    = is_item(w_td) ? w_hd : itp;
                            n_td    = itp;
                            n_last  = w_td;
                            q_we    = 1'b1;
                            q_wd    = {n_hd, n_td};
                            // old tail gets its link in a second write
                            if (is_item(w_td)) begin
                                n_state = S_LINK2;
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            link_we = 1'b1;
                            link_wa = IDX_W'(r_item);
                            link_wd = w_hd;
                            n_hd    = itp;
                            n_td    = is_item(w_td) ? w_td : itp;
                            q_we    = 1'b1;
                            q_wd    = {n_hd, n_td};
                        end
                        CMD_POP_FRONT: begin
                            if (!is_item(w_hd)) begin
                                n_st = ST_EMPTY;
                            end else begin
                                link_ra  = IDX_W'(w_hd);
                                n_popped = ITEM_W'(w_hd);
                                n_pvalid = 1'b1;
                                n_state  = S_POPW;
                            end
                        end
                        CMD_APPEND: begin
                            if (is_item(w_hs)) begin
                                if (is_item(w_hd) && is_item(w_td)) begin
                                    link_we = 1'b1;
                                    link_wa = IDX_W'(w_td);
                                    link_wd = w_hs;
                                end
                                n_hd    = is_item(w_hd) ? w_hd : w_hs;
                                n_td    = w_ts;
                                q_we    = 1'b1;
                                q_wd    = {n_hd, n_td};
                                n_src   = {NIL_PTR, NIL_PTR};
                                n_state = S_SRCW;
                            end
                        end
                        CMD_PREPEND: begin
                            if (is_item(w_hs)) begin
                                if (is_item(w_ts)) begin
                                    link_we = 1'b1;
                                    link_wa = IDX_W'(w_ts);
                                    link_wd = w_hd;
                                end
                                n_hd    = w_hs;
                                n_td    = is_item(w_td) ? w_td : w_ts;
                                q_we    = 1'b1;
                                q_wd    = {n_hd, n_td};
                                n_src   = {NIL_PTR, NIL_PTR};
                                n_state = S_SRCW;
                            end
                        end
                        CMD_SPLIT: begin
                            if (is_item(w_hd)) begin
                                n_st = ST_BAD;
                            end else if ((r_count != '0) && is_item(w_hs)) begin
                                link_ra = IDX_W'(w_hs);
                                n_last  = w_hs;
                                n_walk  = COUNT_W'(1);
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_LINK2: begin
                link_we = 1'b1;
                link_wa = IDX_W'(r_last);
                link_wd = itp;
                n_state = S_DONE;
            end

            S_POPW: begin
                n_hd    = link_rd;
                n_td    = is_item(link_rd) ? r_td : NIL_PTR;
                q_we    = 1'b1;
                q_wd    = {n_hd, n_td};
                n_state = S_DONE;
            end

            S_WALK: begin
                if ((r_walk < r_count) && is_item(link_rd)) begin
                    n_last  = link_rd;
                    n_walk  = r_walk + COUNT_W'(1);
                    link_ra = IDX_W'(link_rd);
                end else begin
                    // link_rd is the remainder of the source queue
                    link_we = 1'b1;
                    link_wa = IDX_W'(r_last);
                    link_wd = NIL_PTR;
                    n_hd    = r_hs;
                    n_td    = r_last;
                    q_we    = 1'b1;
                    q_wd    = {r_hs, r_last};
                    n_src   = {link_rd, is_item(link_rd) ? r_ts : NIL_PTR};
                    n_state = S_SRCW;
                end
            end

            S_SRCW: begin
                q_we    = 1'b1;
                q_wa    = si;
                q_wd    = r_src;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_ovld || !i_stall) begin
                    n_ovld    = 1'b1;
                    n_o_item  = r_popped;
                    n_o_ival  = r_pvalid;
                    n_o_st    = r_st;
                    n_o_empty = !d_item;
                    n_o_front = d_item ? ITEM_W'(r_hd) : '0;
                    n_o_back  = (d_item && is_item(r_td)) ? ITEM_W'(r_td) : '0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (q_we) begin
            n_qvld[q_wa] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_qsel    <= n_qsel;
        r_oq      <= n_oq;
        r_item    <= n_item;
        r_count   <= n_count;
        r_hd      <= n_hd;
        r_td      <= n_td;
        r_hs      <= n_hs;
        r_ts      <= n_ts;
        r_last    <= n_last;
        r_walk    <= n_walk;
        r_src     <= n_src;
        r_st      <= n_st;
        r_popped  <= n_popped;
        r_pvalid  <= n_pvalid;
        r_vld_d   <= n_vld_d;
        r_vld_s   <= n_vld_s;
        r_o_item  <= n_o_item;
        r_o_ival  <= n_o_ival;
        r_o_st    <= n_o_st;
        r_o_empty <= n_o_empty;
        r_o_front <= n_o_front;
        r_o_back  <= n_o_back;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qvld  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qvld  <= n_qvld;
            r_ovld  <= n_ovld;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovld;
    assign o_item_out    = r_o_item;
    assign o_item_valid  = r_o_ival;
    assign o_status      = r_o_st;
    assign o_queue_empty = r_o_empty;
    assign o_front_item  = r_o_front;
    assign o_back_item   = r_o_back;

`ifndef ASSERT_OFF
    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_FETCH))
        else $error("accepted word did not start a fetch");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_walk != '0) && (r_walk <= r_count)))
        else $error("split walk went past count");

    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_valid) |-> (o_status == ST_DONE))
        else $error("popped item with non-done status");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_queue_empty) |-> ((o_front_item == '0) && (o_back_item == '0)))
        else $error("empty queue reports front or back item");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> (o_queue_empty && !o_item_valid))
        else $error("empty-pop status on a non-empty queue");
`endif

endmodule

`default_nettype wire

// File: tb/linked_list_queue_manager_top_tb.sv
// Self-checking testbench for linked_list_queue_manager_top: a short directed table, then
// random command words, checked against a behavioral model of the queues and links.
// Depends on llqm_pkg and the RTL of the queue manager.
`default_nettype none

module linked_list_queue_manager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import llqm_pkg::*;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [QSEL_W-1:0]   t_qsel;
    typedef logic [ITEM_W-1:0]   t_item;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [STATUS_W-1:0] t_status;

    // reserved command codes, handled as no-ops
    localparam t_cmd CMD_RSVD_6 = 3'd6;
    localparam t_cmd CMD_RSVD_7 = 3'd7;

    localparam int RANDOM_WORDS = 1000;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int PLAN_ROWS    = 25;

    typedef struct packed {
        t_item   item;
        logic    item_valid;
        t_status status;
        logic    empty;
        t_item   front;
        t_item   back;
    } t_queue_report;

    typedef struct packed {
        t_cmd          cmd;
        t_qsel         dst;
        t_qsel         src;
        t_item         item;
        t_count        cnt;
        logic          typed;
        t_queue_report want;
    } t_plan_row;

    localparam t_queue_report NO_REPORT = '0;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   i_stall       = 1'b0;
    t_cmd   i_cmd         = '0;
    t_qsel  i_queue_sel   = '0;
    t_qsel  i_other_queue = '0;
    t_item  i_item_in     = '0;
    t_count i_count       = '0;

    logic    o_stall;
    logic    o_valid;
    t_item   o_item_out;
    logic    o_item_valid;
    t_status o_status;
    logic    o_queue_empty;
    t_item   o_front_item;
    t_item   o_back_item;

    linked_list_queue_manager_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_queue_sel   (i_queue_sel),
        .i_other_queue (i_other_queue),
        .i_item_in     (i_item_in),
        .i_count       (i_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item_out    (o_item_out),
        .o_item_valid  (o_item_valid),
        .o_status      (o_status),
        .o_queue_empty (o_queue_empty),
        .o_front_item  (o_front_item),
        .o_back_item   (o_back_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model of the queue state
    t_ptr link_mem [NUM_ITEMS];
    t_ptr head_q   [NUM_QUEUES];
    t_ptr tail_q   [NUM_QUEUES];
    bit   in_use   [NUM_ITEMS];

    t_queue_report pending_reports [$];
    t_plan_row     plan [PLAN_ROWS];
    int            fail_count  = 0;
    int            cycle_count = 0;
    bit            burst       = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit ptr_live(input t_ptr p);
        return p < t_ptr'(NUM_ITEMS);
    endfunction

    function automatic t_ptr follow_link(input t_ptr p);
        return ptr_live(p) ? link_mem[p[IDX_W-1:0]] : NIL_PTR;
    endfunction

    function automatic int draw_idle();
        return burst ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Applies one command to the model and returns the report it should produce.
    function automatic t_queue_report apply_command(input t_cmd cmd, input t_qsel d,
                                                    input t_qsel s, input t_item it,
                                                    input t_count cnt);
        t_queue_report r;
        bit            two_q;
        t_ptr          hd;
        t_ptr          last;
        t_ptr          nx;
        t_ptr          rest;
        r       = '0;
        r.empty = 1'b1;
        two_q   = (cmd == CMD_APPEND || cmd == CMD_PREPEND || cmd == CMD_SPLIT);
        if (int'(d) >= NUM_QUEUES || (two_q && int'(s) >= NUM_QUEUES)) begin
            r.status = ST_BAD;
        end else if (two_q && s == d) begin
            r.status = ST_BAD;
        end else if ((cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT)
                     && int'(it) >= NUM_ITEMS) begin
            r.status = ST_BAD;
        end else begin
            case (cmd)
                CMD_PUSH_BACK: begin
                    link_mem[it] = NIL_PTR;
                    if (!ptr_live(tail_q[d])) head_q[d] = t_ptr'(it);
                    else link_mem[tail_q[d][IDX_W-1:0]] = t_ptr'(it);
                    tail_q[d] = t_ptr'(it);
                end
                CMD_PUSH_FRONT: begin
                    link_mem[it] = head_q[d];
                    head_q[d]    = t_ptr'(it);
                    if (!ptr_live(tail_q[d])) tail_q[d] = t_ptr'(it);
                end
                CMD_POP_FRONT: begin
                    hd = head_q[d];
                    if (!ptr_live(hd)) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.item       = hd[ITEM_W-1:0];
                        r.item_valid = 1'b1;
                        head_q[d]    = follow_link(hd);
                        if (!ptr_live(head_q[d])) tail_q[d] = NIL_PTR;
                    end
                end
                CMD_APPEND: begin
                    if (ptr_live(head_q[s])) begin
                        if (!ptr_live(head_q[d])) head_q[d] = head_q[s];
                        else link_mem[tail_q[d][IDX_W-1:0]] = head_q[s];
                        tail_q[d] = tail_q[s];
                        head_q[s] = NIL_PTR;
                        tail_q[s] = NIL_PTR;
                    end
                end
                CMD_PREPEND: begin
                    if (ptr_live(head_q[s])) begin
                        if (ptr_live(tail_q[s])) link_mem[tail_q[s][IDX_W-1:0]] = head_q[d];
                        head_q[d] = head_q[s];
                        if (!ptr_live(tail_q[d])) tail_q[d] = tail_q[s];
                        head_q[s] = NIL_PTR;
                        tail_q[s] = NIL_PTR;
                    end
                end
                CMD_SPLIT: begin
                    if (ptr_live(head_q[d])) begin
                        r.status = ST_BAD;
                    end else if (cnt != '0 && ptr_live(head_q[s])) begin
                        // walk to the last item that moves
                        last = head_q[s];
                        for (int i = 1; i < int'(cnt); i++) begin
                            nx = follow_link(last);
                            if (!ptr_live(nx)) break;
                            last = nx;
                        end
                        rest = follow_link(last);
                        link_mem[last[IDX_W-1:0]] = NIL_PTR;
                        head_q[d] = head_q[s];
                        tail_q[d] = last;
                        head_q[s] = rest;
                        if (!ptr_live(rest)) tail_q[s] = NIL_PTR;
                    end
                end
                default: ;
            endcase
        end
        if (int'(d) < NUM_QUEUES && ptr_live(head_q[d])) begin
            r.empty = 1'b0;
            r.front = head_q[d][ITEM_W-1:0];
            r.back  = ptr_live(tail_q[d]) ? tail_q[d][ITEM_W-1:0] : '0;
        end
        return r;
    endfunction

    function automatic bit pick_free_item(output t_item it);
        int start;
        int idx;
        start = $urandom_range(0, NUM_ITEMS - 1);
        it    = '0;
        for (int k = 0; k < NUM_ITEMS; k++) begin
            idx = (start + k) % NUM_ITEMS;
            if (!in_use[idx]) begin
                it = t_item'(idx);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Entered and left in the time step of a rising edge; leaves i_valid high.
    task automatic send_word(input t_cmd cmd, input t_qsel d, input t_qsel s,
                             input t_item it, input t_count cnt,
                             input logic typed, input t_queue_report typed_rep);
        int            gap;
        t_queue_report rep;
        gap = draw_idle();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_queue_sel   <= d;
        i_other_queue <= s;
        i_item_in     <= it;
        i_count       <= cnt;
        do @(posedge i_clk); while (o_stall);
        rep = apply_command(cmd, d, s, it, cnt);
        if ((cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) && rep.status == ST_DONE)
            in_use[it] = 1'b1;
        if (rep.item_valid) in_use[rep.item] = 1'b0;
        pending_reports.push_back(typed ? typed_rep : rep);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stall before each word, then check it
    initial begin : result_sink
        int            hold;
        t_queue_report got;
        t_queue_report want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = draw_idle();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = '{o_item_out, o_item_valid, o_status, o_queue_empty,
                    o_front_item, o_back_item};
            if (pending_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: item=%0d v=%0b st=%0d empty=%0b front=%0d back=%0d",
                             got.item, got.item_valid, got.status, got.empty,
                             got.front, got.back);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch exp: item=%0d v=%0b st=%0d empty=%0b front=%0d back=%0d",
                                 want.item, want.item_valid, want.status, want.empty,
                                 want.front, want.back);
                        $display("         got: item=%0d v=%0b st=%0d empty=%0b front=%0d back=%0d",
                                 got.item, got.item_valid, got.status, got.empty,
                                 got.front, got.back);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int     pick;
        int     q;
        t_cmd   cmd;
        t_qsel  d;
        t_qsel  s;
        t_item  it;
        t_count cnt;

        for (int k = 0; k < NUM_ITEMS; k++) begin
            link_mem[k] = '0;
            in_use[k]   = 1'b0;
        end
        for (int k = 0; k < NUM_QUEUES; k++) begin
            head_q[k] = NIL_PTR;
            tail_q[k] = NIL_PTR;
        end

        plan = '{
            // after reset, pops and pushes at the item extremes
            '{CMD_POP_FRONT,  2'd0, 2'd0, 8'd0,   9'd0, 1'b1,
              '{8'd0, 1'b0, ST_EMPTY, 1'b1, 8'd0,   8'd0}},
            '{CMD_PUSH_BACK,  2'd0, 2'd0, 8'd0,   9'd0, 1'b1,
              '{8'd0, 1'b0, ST_DONE,  1'b0, 8'd0,   8'd0}},
            '{CMD_PUSH_BACK,  2'd0, 2'd0, 8'd255, 9'd0, 1'b1,
              '{8'd0, 1'b0, ST_DONE,  1'b0, 8'd0,   8'd255}},
            '{CMD_PUSH_FRONT, 2'd0, 2'd0, 8'd7,   9'd0, 1'b1,
              '{8'd0, 1'b0, ST_DONE,  1'b0, 8'd7,   8'd255}},
            '{CMD_PUSH_FRONT, 2'd1, 2'd0, 8'd128, 9'd0, 1'b1,
              '{8'd0, 1'b0, ST_DONE,  1'b0, 8'd128, 8'd128}},
            // same queue twice, busy split target, zero count
            '{CMD_APPEND,     2'd0, 2'd0, 8'd0,   9'd0, 1'b1,
              '{8'd0, 1'b0, ST_BAD,   1'b0, 8'd7,   8'd255}},
            '{CMD_SPLIT,      2'd1, 2'd0, 8'd0,   9'd1, 1'b1,
              '{8'd0, 1'b0, ST_BAD,   1'b0, 8'd128, 8'd128}},
            '{CMD_SPLIT,      2'd2, 2'd0, 8'd0,   9'd0, 1'b1,
              '{8'd0, 1'b0, ST_DONE,  1'b1, 8'd0,   8'd0}},
            '{CMD_SPLIT,      2'd2, 2'd0, 8'd0,   9'd2,   1'b0, NO_REPORT},
            '{CMD_APPEND,     2'd2, 2'd1, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_PREPEND,    2'd3, 2'd2, 8'd0,   9'd0,   1'b0, NO_REPORT},
            // empty sources, then a one-item source
            '{CMD_PREPEND,    2'd3, 2'd1, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_APPEND,     2'd1, 2'd2, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_PREPEND,    2'd3, 2'd0, 8'd0,   9'd0,   1'b0, NO_REPORT},
            // count beyond the source length
            '{CMD_SPLIT,      2'd1, 2'd3, 8'd0,   9'd511, 1'b0, NO_REPORT},
            '{CMD_SPLIT,      2'd2, 2'd1, 8'd0,   9'd256, 1'b0, NO_REPORT},
            '{CMD_RSVD_6,     2'd2, 2'd0, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_RSVD_7,     2'd1, 2'd3, 8'd255, 9'd511, 1'b0, NO_REPORT},
            '{CMD_POP_FRONT,  2'd2, 2'd0, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_POP_FRONT,  2'd2, 2'd0, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_PUSH_BACK,  2'd3, 2'd0, 8'd1,   9'd0,   1'b0, NO_REPORT},
            '{CMD_PUSH_FRONT, 2'd3, 2'd0, 8'd254, 9'd0,   1'b0, NO_REPORT},
            '{CMD_POP_FRONT,  2'd3, 2'd0, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_POP_FRONT,  2'd3, 2'd0, 8'd0,   9'd0,   1'b0, NO_REPORT},
            '{CMD_POP_FRONT,  2'd3, 2'd0, 8'd0,   9'd0, 1'b1,
              '{8'd0, 1'b0, ST_EMPTY, 1'b1, 8'd0,   8'd0}}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_ROWS; r++)
            send_word(plan[r].cmd, plan[r].dst, plan[r].src, plan[r].item, plan[r].cnt,
                      plan[r].typed, plan[r].want);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_WORDS / 2) wait_for_drain();
            pick = $urandom_range(0, 99);
            d    = t_qsel'($urandom_range(0, 3));
            s    = t_qsel'($urandom_range(0, 3));
            it   = t_item'($urandom_range(0, 255));
            cnt  = t_count'($urandom_range(0, 511));
            if (pick < 30) begin
                cmd = (pick < 18) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                // mostly items not queued anywhere; rarely a duplicate
                if ($urandom_range(0, 49) != 0 && !pick_free_item(it)) cmd = CMD_POP_FRONT;
            end else if (pick < 60) begin
                cmd = CMD_POP_FRONT;
            end else if (pick < 68) begin
                cmd = CMD_APPEND;
            end else if (pick < 76) begin
                cmd = CMD_PREPEND;
            end else if (pick < 96) begin
                cmd = CMD_SPLIT;
            end else begin
                cmd = ($urandom_range(0, 1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7;
            end
            if ((cmd == CMD_APPEND || cmd == CMD_PREPEND || cmd == CMD_SPLIT)
                && s == d && $urandom_range(0, 9) != 0)
                s = d + t_qsel'(1);
            if (cmd == CMD_SPLIT) begin
                // steer toward an empty destination most of the time
                if (ptr_live(head_q[d]) && $urandom_range(0, 4) != 0) begin
                    q = $urandom_range(0, NUM_QUEUES - 1);
                    for (int k = 0; k < NUM_QUEUES; k++) begin
                        if (!ptr_live(head_q[(q + k) % NUM_QUEUES])
                            && t_qsel'((q + k) % NUM_QUEUES) != s) begin
                            d = t_qsel'((q + k) % NUM_QUEUES);
                            break;
                        end
                    end
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: cnt = t_count'($urandom_range(0, 8));
                    6, 7, 8:          cnt = t_count'($urandom_range(0, 64));
                    default:          cnt = t_count'($urandom_range(0, 511));
                endcase
            end
            send_word(cmd, d, s, it, cnt, 1'b0, NO_REPORT);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
